// ===== rtl/tagged_order_queue_defines.svh =====
// Assertion macros for the tagged order queue.
`ifndef TAGGED_ORDER_QUEUE_DEFINES_SVH
`define TAGGED_ORDER_QUEUE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TOQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define TOQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TOQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define TOQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/toq_pkg.sv =====
// Types and constants shared by the tagged order queue.
`default_nettype none
package toq_pkg;
    localparam int W_ID  = 16;
    localparam int W_AMT = 31;
    localparam int W_NUM = 32;
    localparam int W_ST  = 3;

    localparam logic [W_NUM-1:0] FIRST_NUM_RESET = 32'd1;

    localparam int CQ_DEPTH = 2;
    localparam int CQ_PW    = 1;
    localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

    typedef enum logic [W_ST-1:0] {
        ST_ENQ     = 3'd0,
        ST_DEQ     = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_NOMATCH = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_ENQ   = 2'd0,
        OP_DEQ   = 2'd1,
        OP_ADMIN = 2'd2
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [W_ID-1:0]  buyer_id;
        logic [W_ID-1:0]  seller_id;
        logic [W_AMT-1:0] amount;
        logic [W_ID-1:0]  detail_tag;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fr_stat;

    typedef struct packed {
        logic pop;
        logic exec;
    } t_bk_stat;
endpackage
`default_nettype wire

// ===== rtl/toq_if.sv =====
// Valid/ready channel interfaces for order words and result words.
`default_nettype none
interface toq_in_if;
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [toq_pkg::W_ID-1:0]   buyer_id;
    logic [toq_pkg::W_ID-1:0]   seller_id;
    logic [toq_pkg::W_AMT-1:0]  amount;
    logic [toq_pkg::W_ID-1:0]   detail_tag;
    logic                       is_admin;

    modport source(output valid, func, buyer_id, seller_id, amount, detail_tag, is_admin,
                   input ready);
    modport sink(input valid, func, buyer_id, seller_id, amount, detail_tag, is_admin,
                 output ready);
endinterface

interface toq_out_if;
    logic                       valid;
    logic                       ready;
    logic [toq_pkg::W_ST-1:0]   status;
    logic [toq_pkg::W_NUM-1:0]  order_number;
    logic [toq_pkg::W_ID-1:0]   out_buyer;
    logic [toq_pkg::W_ID-1:0]   out_seller;
    logic [toq_pkg::W_AMT-1:0]  out_amount;
    logic [toq_pkg::W_ID-1:0]   out_detail;

    modport source(output valid, status, order_number, out_buyer, out_seller, out_amount,
                   out_detail, input ready);
    modport sink(input valid, status, order_number, out_buyer, out_seller, out_amount,
                 out_detail, output ready);
endinterface
`default_nettype wire

// ===== rtl/tagged_order_queue.sv =====
// Tagged order queue: numbered order FIFO with oldest-by-seller removal.
//
// i_ord carries one order word per valid/ready handshake: func 0 enqueues
// buyer, seller, amount and detail tag; func 1 dequeues, the oldest order
// when is_admin is set, else the oldest order of seller_id.
// o_res returns exactly one result word per order word, in order: status,
// order number and, for a dequeue, the removed order's fields.
// A two-entry command queue sits between intake and execution, so i_ord
// keeps accepting while a result waits on o_res.
// In the execution unit a command first registers the per-cell seller
// match, then does first-match select, compaction and the result
// register. It takes a new command only when idle and when o_res holds
// no result or is ready.
// i_cfg_we with i_cfg_wdata loads the number of the next order; write it
// only while no word is in flight.
// Reset (i_rst_n low, synchronous) empties the queue and sets the next
// order number to 1. When o_res is stalled, the held result stays, the
// execution unit takes no new command, the command queue fills with two
// words, then i_ord.ready drops.
`default_nettype none
`include "tagged_order_queue_defines.svh"
module tagged_order_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    toq_in_if.sink                          i_ord,
    toq_out_if.source                       o_res,
    input  wire logic                       i_cfg_we,
    input  wire logic [toq_pkg::W_NUM-1:0]  i_cfg_wdata
);
    localparam int OW = $clog2(DEPTH + 1);

    logic                   w_cmd_valid, w_cmd_ready;
    toq_pkg::t_cmd          w_cmd;
    toq_pkg::t_fr_stat      w_fr_stat;
    toq_pkg::t_bk_stat      w_bk_stat;
    logic [OW-1:0]          w_occ;

    toq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ord       (i_ord),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd),
        .o_stat      (w_fr_stat)
    );

    toq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res       (o_res),
        .o_occ       (w_occ),
        .o_stat      (w_bk_stat)
    );

    `TOQ_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, w_bk_stat.pop, !w_fr_stat.empty, "pop from empty command queue")
    `TOQ_ASSERT_IMP(a_res_from_exec, i_clk, i_rst_n, $rose(o_res.valid), $past(w_bk_stat.exec), "result word without executed command")
    `TOQ_ASSERT_IMP(a_occ_step, i_clk, i_rst_n, 1'b1, (w_occ == $past(w_occ)) || (w_occ == $past(w_occ) + 1'b1) || (w_occ + 1'b1 == $past(w_occ)), "occupancy moved by more than one")
    `TOQ_ASSERT_IMP(a_occ_bound, i_clk, i_rst_n, w_bk_stat.exec, $past(w_occ) <= OW'(DEPTH), "occupancy above depth")
endmodule
`default_nettype wire

// ===== rtl/toq_front.sv =====
// Front end: accepts order words, classifies them and buffers commands.
`default_nettype none
module toq_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    toq_in_if.sink               i_ord,
    output logic                 o_cmd_valid,
    input  wire logic            i_cmd_ready,
    output toq_pkg::t_cmd        o_cmd,
    output toq_pkg::t_fr_stat    o_stat
);
    toq_pkg::t_cmd                  r_q [toq_pkg::CQ_DEPTH];
    logic [toq_pkg::CQ_PW-1:0]      r_wp, n_wp;
    logic [toq_pkg::CQ_PW-1:0]      r_rp, n_rp;
    logic [toq_pkg::CQ_CW-1:0]      r_cnt, n_cnt;
    toq_pkg::t_cmd                  w_cmd;
    logic                           w_push, w_pop;

    always_comb begin
        w_cmd.buyer_id   = i_ord.buyer_id;
        w_cmd.seller_id  = i_ord.seller_id;
        w_cmd.amount     = i_ord.amount;
        w_cmd.detail_tag = i_ord.detail_tag;
        if (!i_ord.func) begin
            w_cmd.op = toq_pkg::OP_ENQ;
        end else if (i_ord.is_admin) begin
            w_cmd.op = toq_pkg::OP_ADMIN;
        end else begin
            w_cmd.op = toq_pkg::OP_DEQ;
        end
    end

    assign o_stat.full  = (r_cnt == toq_pkg::CQ_CW'(toq_pkg::CQ_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign i_ord.ready  = !o_stat.full;
    assign o_cmd_valid  = !o_stat.empty;
    assign o_cmd        = r_q[r_rp];

    assign w_push = i_ord.valid && i_ord.ready;
    assign w_pop  = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_wp  = w_push ? r_wp + 1'b1 : r_wp;
        n_rp  = w_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/toq_back.sv =====
// Back end: order cells with seller match, first-match removal and numbering.
`default_nettype none
module toq_back #(
    parameter  int DEPTH = 16,
    localparam int OW    = $clog2(DEPTH + 1)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cmd_valid,
    output logic                            o_cmd_ready,
    input  wire toq_pkg::t_cmd              i_cmd,
    input  wire logic                       i_cfg_we,
    input  wire logic [toq_pkg::W_NUM-1:0]  i_cfg_wdata,
    toq_out_if.source                       o_res,
    output logic [OW-1:0]                   o_occ,
    output toq_pkg::t_bk_stat               o_stat
);
    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_EXEC = 2'b10
    } t_bk_state;

    t_bk_state                      r_state, n_state;
    logic [OW-1:0]                  r_occ, n_occ;
    logic [toq_pkg::W_NUM-1:0]      r_next, n_next;
    toq_pkg::t_cmd                  r_cmd;
    logic [DEPTH-1:0]               r_match;

    logic [toq_pkg::W_NUM-1:0]      r_num [DEPTH];
    logic [toq_pkg::W_ID-1:0]       r_buy [DEPTH];
    logic [toq_pkg::W_ID-1:0]       r_sel [DEPTH];
    logic [toq_pkg::W_AMT-1:0]      r_amt [DEPTH];
    logic [toq_pkg::W_ID-1:0]       r_det [DEPTH];

    logic                           r_out_valid;
    toq_pkg::t_status               r_out_st, n_out_st;
    logic [toq_pkg::W_NUM-1:0]      r_out_num, n_out_num;
    logic [toq_pkg::W_ID-1:0]       r_out_buy, n_out_buy;
    logic [toq_pkg::W_ID-1:0]       r_out_sel, n_out_sel;
    logic [toq_pkg::W_AMT-1:0]      r_out_amt, n_out_amt;
    logic [toq_pkg::W_ID-1:0]       r_out_det, n_out_det;

    logic                           w_pop, w_exec, w_full, w_hit, w_enq_ok, w_deq_ok;
    logic [DEPTH-1:0]               w_first, w_shift;
    logic [toq_pkg::W_NUM-1:0]      w_s_num;
    logic [toq_pkg::W_ID-1:0]       w_s_buy, w_s_sel, w_s_det;
    logic [toq_pkg::W_AMT-1:0]      w_s_amt;

    assign o_cmd_ready = (r_state == BK_IDLE) && (!r_out_valid || o_res.ready);
    assign w_pop       = i_cmd_valid && o_cmd_ready;
    assign w_exec      = (r_state == BK_EXEC);
    assign o_stat.pop  = w_pop;
    assign o_stat.exec = w_exec;
    assign o_occ       = r_occ;

    // lowest matching cell, and the cells at or above it that shift down
    assign w_first  = r_match & (~r_match + DEPTH'(1));
    assign w_shift  = ~(w_first - DEPTH'(1));
    assign w_hit    = |r_match;
    assign w_full   = (r_occ == OW'(DEPTH));
    assign w_enq_ok = w_exec && (r_cmd.op == toq_pkg::OP_ENQ) && !w_full;
    assign w_deq_ok = w_exec && (r_cmd.op != toq_pkg::OP_ENQ) && w_hit;

    always_comb begin
        w_s_num = '0;
        w_s_buy = '0;
        w_s_sel = '0;
        w_s_amt = '0;
        w_s_det = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (w_first[k]) begin
                w_s_num = w_s_num | r_num[k];
                w_s_buy = w_s_buy | r_buy[k];
                w_s_sel = w_s_sel | r_sel[k];
                w_s_amt = w_s_amt | r_amt[k];
                w_s_det = w_s_det | r_det[k];
            end
        end
    end

    always_comb begin
        n_out_st  = toq_pkg::ST_ENQ;
        n_out_num = '0;
        n_out_buy = '0;
        n_out_sel = '0;
        n_out_amt = '0;
        n_out_det = '0;
        n_occ     = r_occ;
        n_next    = r_next;
        if (r_cmd.op == toq_pkg::OP_ENQ) begin
            if (w_full) begin
                n_out_st = toq_pkg::ST_FULL;
            end else begin
                n_out_num = r_next;
                n_next    = r_next + 1'b1;
                n_occ     = r_occ + 1'b1;
            end
        end else if (r_occ == '0) begin
            n_out_st = toq_pkg::ST_EMPTY;
        end else if (!w_hit) begin
            n_out_st = toq_pkg::ST_NOMATCH;
        end else begin
            n_out_st  = toq_pkg::ST_DEQ;
            n_out_num = w_s_num;
            n_out_buy = w_s_buy;
            n_out_sel = w_s_sel;
            n_out_amt = w_s_amt;
            n_out_det = w_s_det;
            n_occ     = r_occ - 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (w_pop) begin
                    n_state = BK_EXEC;
                end
            end
            BK_EXEC: begin
                n_state = BK_IDLE;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_occ       <= '0;
            r_next      <= toq_pkg::FIRST_NUM_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_exec) begin
                r_occ <= n_occ;
            end
            if (i_cfg_we) begin
                r_next <= i_cfg_wdata;
            end else if (w_exec) begin
                r_next <= n_next;
            end
            if (w_exec) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_cmd <= i_cmd;
        end
        if (w_exec) begin
            r_out_st  <= n_out_st;
            r_out_num <= n_out_num;
            r_out_buy <= n_out_buy;
            r_out_sel <= n_out_sel;
            r_out_amt <= n_out_amt;
            r_out_det <= n_out_det;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam int NX = (g + 1 < DEPTH) ? g + 1 : g;

        always_ff @(posedge i_clk) begin
            if (w_pop) begin
                r_match[g] <= (OW'(g) < r_occ) &&
                              ((i_cmd.op == toq_pkg::OP_ADMIN) ||
                               (r_sel[g] == i_cmd.seller_id));
            end
            if (w_enq_ok && (OW'(g) == r_occ)) begin
                r_num[g] <= r_next;
                r_buy[g] <= r_cmd.buyer_id;
                r_sel[g] <= r_cmd.seller_id;
                r_amt[g] <= r_cmd.amount;
                r_det[g] <= r_cmd.detail_tag;
            end else if (w_deq_ok && w_shift[g]) begin
                r_num[g] <= r_num[NX];
                r_buy[g] <= r_buy[NX];
                r_sel[g] <= r_sel[NX];
                r_amt[g] <= r_amt[NX];
                r_det[g] <= r_det[NX];
            end
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out_st;
    assign o_res.order_number = r_out_num;
    assign o_res.out_buyer    = r_out_buy;
    assign o_res.out_seller   = r_out_sel;
    assign o_res.out_amount   = r_out_amt;
    assign o_res.out_detail   = r_out_det;
endmodule
`default_nettype wire

// ===== dv/tb_tagged_order_queue.sv =====
// Self-checking testbench for tagged_order_queue: directed and random order traffic against a queue model.
`default_nettype none
module tb_tagged_order_queue;
    localparam int BOOK_DEPTH  = 16;
    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 8;

    typedef struct {
        bit                        func;
        logic [toq_pkg::W_ID-1:0]  buyer;
        logic [toq_pkg::W_ID-1:0]  seller;
        logic [toq_pkg::W_AMT-1:0] amount;
        logic [toq_pkg::W_ID-1:0]  detail;
        bit                        admin;
        int                        gap;
    } t_order;

    typedef struct {
        toq_pkg::t_status          status;
        logic [toq_pkg::W_NUM-1:0] number;
        logic [toq_pkg::W_ID-1:0]  buyer;
        logic [toq_pkg::W_ID-1:0]  seller;
        logic [toq_pkg::W_AMT-1:0] amount;
        logic [toq_pkg::W_ID-1:0]  detail;
    } t_outcome;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [toq_pkg::W_NUM-1:0] i_cfg_wdata;

    toq_in_if  ord_if();
    toq_out_if res_if();

    tagged_order_queue #(.DEPTH(BOOK_DEPTH)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ord       (ord_if.sink),
        .o_res       (res_if.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // order book model
    logic [toq_pkg::W_NUM-1:0] book_num    [BOOK_DEPTH];
    logic [toq_pkg::W_ID-1:0]  book_buyer  [BOOK_DEPTH];
    logic [toq_pkg::W_ID-1:0]  book_seller [BOOK_DEPTH];
    logic [toq_pkg::W_AMT-1:0] book_amount [BOOK_DEPTH];
    logic [toq_pkg::W_ID-1:0]  book_detail [BOOK_DEPTH];
    int                        book_count;
    logic [toq_pkg::W_NUM-1:0] next_num;

    t_order   order_words[$];
    t_outcome expected_outcomes[$];
    t_order   next_word;
    t_order   on_wire;
    t_outcome drv_outcome;
    t_outcome mon_outcome;
    bit       staged;
    bit       drv_next_valid;
    int       drv_wait;
    bit       no_idle;
    bit       hold_request;
    int       long_hold;
    int       rdy_wait;
    int       idle_cycles;
    int       fails;
    int       words_in;
    int       results_checked;
    int       cfg_writes;
    int       status_seen[5];

    always #1 i_clk = ~i_clk;

    function automatic int draw_gap();
        if (no_idle || $urandom_range(0, 3) == 0) begin
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic void push_word(bit f, logic [toq_pkg::W_ID-1:0] b,
                                      logic [toq_pkg::W_ID-1:0] s,
                                      logic [toq_pkg::W_AMT-1:0] a,
                                      logic [toq_pkg::W_ID-1:0] d, bit adm);
        t_order w;
        w.func   = f;
        w.buyer  = b;
        w.seller = s;
        w.amount = a;
        w.detail = d;
        w.admin  = adm;
        w.gap    = draw_gap();
        order_words.push_back(w);
    endfunction

    function automatic t_outcome book_order(t_order w);
        t_outcome r;
        int       hit;
        r.status = toq_pkg::ST_ENQ;
        r.number = '0;
        r.buyer  = '0;
        r.seller = '0;
        r.amount = '0;
        r.detail = '0;
        if (!w.func) begin
            if (book_count >= BOOK_DEPTH) begin
                r.status = toq_pkg::ST_FULL;
                return r;
            end
            book_num[book_count]    = next_num;
            book_buyer[book_count]  = w.buyer;
            book_seller[book_count] = w.seller;
            book_amount[book_count] = w.amount;
            book_detail[book_count] = w.detail;
            book_count++;
            r.number = next_num;
            next_num = next_num + 32'd1;
            return r;
        end
        if (book_count == 0) begin
            r.status = toq_pkg::ST_EMPTY;
            return r;
        end
        hit = -1;
        for (int k = 0; k < book_count; k++) begin
            if (hit < 0 && (w.admin || book_seller[k] == w.seller)) begin
                hit = k;
            end
        end
        if (hit < 0) begin
            r.status = toq_pkg::ST_NOMATCH;
            return r;
        end
        r.status = toq_pkg::ST_DEQ;
        r.number = book_num[hit];
        r.buyer  = book_buyer[hit];
        r.seller = book_seller[hit];
        r.amount = book_amount[hit];
        r.detail = book_detail[hit];
        for (int k = hit; k + 1 < book_count; k++) begin
            book_num[k]    = book_num[k+1];
            book_buyer[k]  = book_buyer[k+1];
            book_seller[k] = book_seller[k+1];
            book_amount[k] = book_amount[k+1];
            book_detail[k] = book_detail[k+1];
        end
        book_count--;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (act !== exp) begin
            $error("%s: expected %0h, got %0h", name, exp, act);
            fails++;
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ord_if.valid <= 1'b0;
            staged = 1'b0;
        end else begin
            drv_next_valid = ord_if.valid && !ord_if.ready;
            if (ord_if.valid && ord_if.ready) begin
                drv_outcome = book_order(on_wire);
                expected_outcomes.push_back(drv_outcome);
                status_seen[drv_outcome.status]++;
                words_in++;
            end
            if (!drv_next_valid) begin
                if (!staged && order_words.size() > 0) begin
                    next_word = order_words.pop_front();
                    staged    = 1'b1;
                    drv_wait  = next_word.gap;
                end
                if (staged) begin
                    if (drv_wait == 0) begin
                        on_wire = next_word;
                        staged  = 1'b0;
                        drv_next_valid = 1'b1;
                        ord_if.func       <= next_word.func;
                        ord_if.buyer_id   <= next_word.buyer;
                        ord_if.seller_id  <= next_word.seller;
                        ord_if.amount     <= next_word.amount;
                        ord_if.detail_tag <= next_word.detail;
                        ord_if.is_admin   <= next_word.admin;
                    end else begin
                        drv_wait--;
                    end
                end
            end
            ord_if.valid <= drv_next_valid;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            rdy_wait  = 0;
            long_hold = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_outcomes.size() == 0) begin
                    $error("result word with no order word pending: status %0d",
                           res_if.status);
                    fails++;
                end else begin
                    mon_outcome = expected_outcomes.pop_front();
                    check_field("status", 32'(mon_outcome.status), 32'(res_if.status));
                    check_field("order_number", mon_outcome.number, res_if.order_number);
                    check_field("out_buyer", 32'(mon_outcome.buyer), 32'(res_if.out_buyer));
                    check_field("out_seller", 32'(mon_outcome.seller),
                                32'(res_if.out_seller));
                    check_field("out_amount", 32'(mon_outcome.amount),
                                32'(res_if.out_amount));
                    check_field("out_detail", 32'(mon_outcome.detail),
                                32'(res_if.out_detail));
                    results_checked++;
                end
                rdy_wait = draw_gap();
            end
            if (hold_request) begin
                long_hold    = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (long_hold > 0) begin
                long_hold--;
            end else if (rdy_wait > 0) begin
                rdy_wait--;
            end
            res_if.ready <= (long_hold == 0 && rdy_wait == 0);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((ord_if.valid && ord_if.ready) || (res_if.valid && res_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("tagged_order_queue: mismatch");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        @(negedge i_clk);
        while (order_words.size() > 0 || staged || ord_if.valid
               || expected_outcomes.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_first_number(input logic [toq_pkg::W_NUM-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        next_num = val;
        cfg_writes++;
    endtask

    task automatic queue_random(input int count, input int enq_pct);
        logic [toq_pkg::W_ID-1:0] pool[4];
        logic [toq_pkg::W_ID-1:0] s;
        for (int i = 0; i < 4; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                pool[i] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end else begin
                pool[i] = 16'($urandom);
            end
        end
        for (int i = 0; i < count; i++) begin
            s = ($urandom_range(0, 4) == 0) ? 16'($urandom) : pool[$urandom_range(0, 3)];
            push_word($urandom_range(0, 99) >= enq_pct, 16'($urandom), s, 31'($urandom),
                      16'($urandom), $urandom_range(0, 3) == 0);
        end
    endtask

    initial begin
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        ord_if.valid      = 1'b0;
        ord_if.func       = 1'b0;
        ord_if.buyer_id   = '0;
        ord_if.seller_id  = '0;
        ord_if.amount     = '0;
        ord_if.detail_tag = '0;
        ord_if.is_admin   = 1'b0;
        res_if.ready      = 1'b0;
        book_count        = 0;
        next_num          = toq_pkg::FIRST_NUM_RESET;
        no_idle           = 1'b0;
        hold_request      = 1'b0;
        staged            = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty, extremes, middle removal, no match, admin, full
        push_word(1'b1, 16'h0000, 16'h0000, 31'h0, 16'h0000, 1'b0);
        push_word(1'b1, 16'h0000, 16'h0000, 31'h0, 16'h0000, 1'b1);
        push_word(1'b0, 16'h0000, 16'hFFFF, 31'h7FFF_FFFF, 16'h0000, 1'b0);
        push_word(1'b0, 16'hFFFF, 16'h0000, 31'h0, 16'hFFFF, 1'b1);
        push_word(1'b0, 16'h1234, 16'h00A5, 31'd77, 16'h0055, 1'b0);
        push_word(1'b1, 16'hFFFF, 16'h0000, 31'h7FFF_FFFF, 16'hFFFF, 1'b0);
        push_word(1'b1, 16'h0000, 16'h1234, 31'h0, 16'h0000, 1'b0);
        push_word(1'b1, 16'h0000, 16'h4321, 31'h0, 16'h0000, 1'b1);
        for (int k = 0; k < BOOK_DEPTH; k++) begin
            push_word(1'b0, 16'($urandom), k[0] ? 16'hFFFF : 16'h0003, 31'($urandom),
                      16'($urandom), 1'b0);
        end
        push_word(1'b1, 16'h0000, 16'h00A5, 31'h0, 16'h0000, 1'b0);
        wait_drained();

        write_first_number(32'hFFFF_FFF0);
        no_idle = 1'b1;
        queue_random(150, 65);
        wait_drained();

        write_first_number(32'h0000_0000);
        no_idle = 1'b0;
        hold_request = 1'b1;
        queue_random(200, 55);
        wait_drained();

        write_first_number(32'hFFFF_FFFF);
        queue_random(200, 35);
        wait_drained();

        write_first_number($urandom);
        queue_random(200, 60);
        wait_drained();

        no_idle = 1'b1;
        hold_request = 1'b1;
        queue_random(75, 45);
        wait_drained();
        no_idle = 1'b0;
        queue_random(75, 45);
        wait_drained();

        $display("Sent %0d order words under %0d numbering settings; %0d results checked.",
                 words_in, cfg_writes + 1, results_checked);
        $display("Outcomes: enqueued %0d, dequeued %0d, empty %0d, no match %0d, full %0d.",
                 status_seen[toq_pkg::ST_ENQ], status_seen[toq_pkg::ST_DEQ],
                 status_seen[toq_pkg::ST_EMPTY], status_seen[toq_pkg::ST_NOMATCH],
                 status_seen[toq_pkg::ST_FULL]);
        if (fails == 0) begin
            $display("tagged_order_queue: match");
        end else begin
            $display("tagged_order_queue: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire
